FILE: sv/sgrap_pkg.sv
// Shared types and constants for the SGR attribute parser.
// No dependencies; imported by every module of the block.
package sgrap_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned AccumW = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned ColorW = 5;

  localparam logic [CharW-1:0]  CHAR_END  = 8'h00;
  localparam logic [CharW-1:0]  CHAR_ZERO = 8'h30;
  localparam logic [CharW-1:0]  CHAR_NINE = 8'h39;

  localparam logic [AccumW-1:0] ACCUM_MAX = 8'hFF;
  localparam logic [CountW-1:0] COUNT_MAX = 8'hFF;

  // Color index value meaning "terminal default".
  localparam logic signed [ColorW-1:0] COLOR_DEFAULT = 5'sh1F;

  // SGR codes
  localparam logic [AccumW-1:0] CODE_RESET     = 8'd0;
  localparam logic [AccumW-1:0] CODE_BOLD_ON   = 8'd1;
  localparam logic [AccumW-1:0] CODE_UL_ON     = 8'd4;
  localparam logic [AccumW-1:0] CODE_REV_ON    = 8'd7;
  localparam logic [AccumW-1:0] CODE_BOLD_OFF  = 8'd22;
  localparam logic [AccumW-1:0] CODE_UL_OFF    = 8'd24;
  localparam logic [AccumW-1:0] CODE_REV_OFF   = 8'd27;
  localparam logic [AccumW-1:0] CODE_FG_LO     = 8'd30;
  localparam logic [AccumW-1:0] CODE_FG_HI     = 8'd37;
  localparam logic [AccumW-1:0] CODE_FG_DEF    = 8'd39;
  localparam logic [AccumW-1:0] CODE_BG_LO     = 8'd40;
  localparam logic [AccumW-1:0] CODE_BG_HI     = 8'd47;
  localparam logic [AccumW-1:0] CODE_BG_DEF    = 8'd49;
  localparam logic [AccumW-1:0] CODE_FG_BR_LO  = 8'd90;
  localparam logic [AccumW-1:0] CODE_FG_BR_HI  = 8'd97;
  localparam logic [AccumW-1:0] CODE_BG_BR_LO  = 8'd100;
  localparam logic [AccumW-1:0] CODE_BG_BR_HI  = 8'd107;

  // Attribute update requested by one closed code.
  typedef struct packed {
    logic                     clr_all;
    logic                     bold_set;
    logic                     bold_val;
    logic                     ul_set;
    logic                     ul_val;
    logic                     rev_set;
    logic                     rev_val;
    logic                     fg_set;
    logic signed [ColorW-1:0] fg_val;
    logic                     bg_set;
    logic signed [ColorW-1:0] bg_val;
  } sgrap_action_t;

endpackage

FILE: sv/sgr_attribute_parser.sv
// SGR attribute parser top level: input register, accumulate/apply logic,
// result register. Depends on sgrap_pkg and sgrap_code_dec.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / char_in_i) carries one byte of
//   an SGR parameter string per beat. Digits build a decimal code; any other
//   byte closes it; a zero byte closes it and ends the string.
//   Output channel (out_valid_o / out_ready_i) carries one result beat per
//   input beat: the attribute state after that byte, the count of codes
//   applied so far in the string, and string_done on the end byte.
// Path: input register, then the per-byte logic, then the result register.
// Throughput: one byte per cycle while out_ready_i is high. The per-byte
//   work is a x10 accumulate with saturation and a small code decode, all
//   between the two registers.
// Reset: attributes go to default colors and all flags off; the code
//   accumulator and per-string count clear; both registers empty.
// Stall: if out_ready_i is low the result register holds, the input register
//   keeps its byte, and in_ready_o drops once both are full. Up to two bytes
//   are buffered, so the sender sees no bubble when the stall releases.
module sgr_attribute_parser
  import sgrap_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // input beats
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [CharW-1:0]         char_in_i,
  // result beats
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ColorW-1:0] fg_color_o,
  output logic signed [ColorW-1:0] bg_color_o,
  output logic                     bold_on_o,
  output logic                     underline_on_o,
  output logic                     reverse_on_o,
  output logic [CountW-1:0]        codes_applied_o,
  output logic                     string_done_o
);

  // ---------------- input register ----------------
  logic             in_vld_q;
  logic [CharW-1:0] char_q;
  logic             s1_adv;
  logic             out_vld_q;

  // Input stage moves on when the result register is free or draining.
  assign s1_adv     = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_q <= char_in_i;
    end
  end

  // ---------------- parser state ----------------
  logic signed [ColorW-1:0] fg_q, fg_d;
  logic signed [ColorW-1:0] bg_q, bg_d;
  logic                     bold_q, bold_d;
  logic                     ul_q, ul_d;
  logic                     rev_q, rev_d;
  logic [AccumW-1:0]        accum_q, accum_d;
  logic                     have_q, have_d;
  logic [CountW-1:0]        count_q, count_d;

  // ---------------- per-byte logic ----------------
  logic                is_digit;
  logic                is_end;
  logic                close_code;
  logic [CharW-1:0]    digit_full;
  logic [AccumW+3:0]   accum_x10;   // up to 255*10+9, fits 12 bits
  logic [AccumW+3:0]   accum_sum;
  logic [CountW-1:0]   count_inc;
  sgrap_action_t       act;

  assign is_digit   = (char_q >= CHAR_ZERO) && (char_q <= CHAR_NINE);
  assign is_end     = (char_q == CHAR_END);
  assign close_code = !is_digit && have_q;
  assign digit_full = char_q - CHAR_ZERO;

  // x10 as shift-and-add: 8a + 2a
  assign accum_x10 = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0};
  assign accum_sum = accum_x10 + {8'h00, digit_full[3:0]};

  sgrap_code_dec u_dec (
    .code_i (accum_q),
    .act_o  (act)
  );

  assign count_inc = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;

  always_comb begin
    fg_d    = fg_q;
    bg_d    = bg_q;
    bold_d  = bold_q;
    ul_d    = ul_q;
    rev_d   = rev_q;
    accum_d = '0;
    have_d  = 1'b0;
    count_d = count_q;

    if (is_digit) begin
      accum_d = (accum_sum > {4'h0, ACCUM_MAX}) ? ACCUM_MAX : accum_sum[AccumW-1:0];
      have_d  = 1'b1;
    end else if (close_code) begin
      count_d = count_inc;
      if (act.clr_all) begin
        fg_d   = COLOR_DEFAULT;
        bg_d   = COLOR_DEFAULT;
        bold_d = 1'b0;
        ul_d   = 1'b0;
        rev_d  = 1'b0;
      end
      if (act.bold_set) bold_d = act.bold_val;
      if (act.ul_set)   ul_d   = act.ul_val;
      if (act.rev_set)  rev_d  = act.rev_val;
      if (act.fg_set)   fg_d   = act.fg_val;
      if (act.bg_set)   bg_d   = act.bg_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q    <= COLOR_DEFAULT;
      bg_q    <= COLOR_DEFAULT;
      bold_q  <= 1'b0;
      ul_q    <= 1'b0;
      rev_q   <= 1'b0;
      accum_q <= '0;
      have_q  <= 1'b0;
      count_q <= '0;
    end else if (s1_adv) begin
      fg_q    <= fg_d;
      bg_q    <= bg_d;
      bold_q  <= bold_d;
      ul_q    <= ul_d;
      rev_q   <= rev_d;
      accum_q <= accum_d;
      have_q  <= have_d;
      // count clears after the end byte; the result still shows it
      count_q <= is_end ? '0 : count_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      fg_color_o      <= fg_d;
      bg_color_o      <= bg_d;
      bold_on_o       <= bold_d;
      underline_on_o  <= ul_d;
      reverse_on_o    <= rev_d;
      codes_applied_o <= count_d;
      string_done_o   <= is_end;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

FILE: sv/sgrap_code_dec.sv
// Decodes one closed SGR code into an attribute update.
// Depends on sgrap_pkg.
module sgrap_code_dec
  import sgrap_pkg::*;
(
  input  logic [AccumW-1:0] code_i,
  output sgrap_action_t     act_o
);

  logic [AccumW-1:0] fg_off;
  logic [AccumW-1:0] bg_off;
  logic [AccumW-1:0] fg_br_off;
  logic [AccumW-1:0] bg_br_off;

  assign fg_off    = code_i - CODE_FG_LO;
  assign bg_off    = code_i - CODE_BG_LO;
  assign fg_br_off = code_i - CODE_FG_BR_LO;
  assign bg_br_off = code_i - CODE_BG_BR_LO;

  always_comb begin
    act_o = '0;
    priority if (code_i == CODE_RESET) begin
      act_o.clr_all = 1'b1;
    end else if (code_i == CODE_BOLD_ON) begin
      act_o.bold_set = 1'b1;
      act_o.bold_val = 1'b1;
    end else if (code_i == CODE_UL_ON) begin
      act_o.ul_set = 1'b1;
      act_o.ul_val = 1'b1;
    end else if (code_i == CODE_REV_ON) begin
      act_o.rev_set = 1'b1;
      act_o.rev_val = 1'b1;
    end else if (code_i == CODE_BOLD_OFF) begin
      act_o.bold_set = 1'b1;
    end else if (code_i == CODE_UL_OFF) begin
      act_o.ul_set = 1'b1;
    end else if (code_i == CODE_REV_OFF) begin
      act_o.rev_set = 1'b1;
    end else if (code_i >= CODE_FG_LO && code_i <= CODE_FG_HI) begin
      act_o.fg_set = 1'b1;
      act_o.fg_val = {2'b00, fg_off[2:0]};
    end else if (code_i == CODE_FG_DEF) begin
      act_o.fg_set = 1'b1;
      act_o.fg_val = COLOR_DEFAULT;
    end else if (code_i >= CODE_BG_LO && code_i <= CODE_BG_HI) begin
      act_o.bg_set = 1'b1;
      act_o.bg_val = {2'b00, bg_off[2:0]};
    end else if (code_i == CODE_BG_DEF) begin
      act_o.bg_set = 1'b1;
      act_o.bg_val = COLOR_DEFAULT;
    end else if (code_i >= CODE_FG_BR_LO && code_i <= CODE_FG_BR_HI) begin
      act_o.fg_set = 1'b1;
      act_o.fg_val = {2'b01, fg_br_off[2:0]};
    end else if (code_i >= CODE_BG_BR_LO && code_i <= CODE_BG_BR_HI) begin
      act_o.bg_set = 1'b1;
      act_o.bg_val = {2'b01, bg_br_off[2:0]};
    end else begin
      act_o = '0;
    end
  end

endmodule

FILE: sv/sgrap_checker.sv
// Port-level checks for the SGR attribute parser, bound to the top level.
// Depends on sgrap_pkg.
module sgrap_checker
  import sgrap_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic [CharW-1:0]         char_in_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [ColorW-1:0] fg_color_o,
  input logic signed [ColorW-1:0] bg_color_o,
  input logic                     bold_on_o,
  input logic                     underline_on_o,
  input logic                     reverse_on_o,
  input logic [CountW-1:0]        codes_applied_o,
  input logic                     string_done_o
);

  // Colors are either default or a valid index 0..15.
  a_fg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!fg_color_o[ColorW-1] || fg_color_o == COLOR_DEFAULT))
    else $error("fg_color out of range");

  a_bg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!bg_color_o[ColorW-1] || bg_color_o == COLOR_DEFAULT))
    else $error("bg_color out of range");

  // Input only backs up when a result is waiting and the receiver stalls.
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("in_ready low without output stall");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(fg_color_o) && $stable(bg_color_o) &&
       $stable(bold_on_o) && $stable(underline_on_o) && $stable(reverse_on_o) &&
       $stable(codes_applied_o) && $stable(string_done_o)))
    else $error("result beat changed while stalled");

  // A waiting input beat holds.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(char_in_i)))
    else $error("input beat changed while waiting");

endmodule

bind sgr_attribute_parser sgrap_checker u_sgrap_checker (.*);
